FILE: sv/icr_pkg.sv
package icr_pkg;

    // Parse phases
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_CODE   = 2'd1;
    localparam logic [1:0] PH_PARAMS = 2'd2;
    localparam logic [1:0] PH_SUM    = 2'd3;

    localparam int          NUM_COUNTS   = 10;
    localparam int          MASK_W       = 13;
    localparam logic [7:0]  END_CODE     = 8'h00;
    localparam logic [7:0]  NORMAL_RESET = 8'h01;
    localparam logic [3:0]  NO_SLOT      = 4'hf;
    localparam logic [1:0]  LAST_PARAM   = 2'd2;

    // Function codes that carry captured parameters
    localparam logic [7:0]  FC_SWITCH     = 8'h01;
    localparam logic [7:0]  FC_COIN       = 8'h02;
    localparam logic [7:0]  FC_ANALOG_IN  = 8'h03;
    localparam logic [7:0]  FC_ROTARY     = 8'h04;
    localparam logic [7:0]  FC_GUN        = 8'h06;
    localparam logic [7:0]  FC_ANALOG_OUT = 8'h13;

    // Capture slots, in output field order
    localparam logic [3:0] SL_PLAYERS    = 4'd0;
    localparam logic [3:0] SL_BUTTONS    = 4'd1;
    localparam logic [3:0] SL_COINS      = 4'd2;
    localparam logic [3:0] SL_AIN_CH     = 4'd3;
    localparam logic [3:0] SL_AIN_BITS   = 4'd4;
    localparam logic [3:0] SL_ROTARY     = 4'd5;
    localparam logic [3:0] SL_GUN_X      = 4'd6;
    localparam logic [3:0] SL_GUN_Y      = 4'd7;
    localparam logic [3:0] SL_GUN_CH     = 4'd8;
    localparam logic [3:0] SL_AOUT_CH    = 4'd9;

    typedef logic [NUM_COUNTS-1:0][7:0] counts_t;

    typedef struct packed {
        logic              status;
        logic [MASK_W-1:0] mask;
        counts_t           counts;
    } result_t;

    // Feature mask bit for a function code, zero for unknown codes
    function automatic logic [MASK_W-1:0] mask_bit_for(input logic [7:0] code);
        logic [MASK_W-1:0] bit_vec;
        bit_vec = '0;
        if (code >= 8'h01 && code <= 8'h07)
        begin
            bit_vec[4'(code - 8'h01)] = 1'b1;
        end
        else if (code >= 8'h10 && code <= 8'h15)
        begin
            bit_vec[4'(code - 8'h10 + 8'd7)] = 1'b1;
        end
        return bit_vec;
    endfunction

    // Capture slot for a parameter byte of a record, NO_SLOT when dropped
    function automatic logic [3:0] count_slot_for(input logic [7:0] code,
                                                  input logic [1:0] idx);
        logic [3:0] slot;
        slot = NO_SLOT;
        unique case (code)
            FC_SWITCH:
            begin
                if (idx == 2'd0)
                    slot = SL_PLAYERS;
                else if (idx == 2'd1)
                    slot = SL_BUTTONS;
            end
            FC_COIN:
            begin
                if (idx == 2'd0)
                    slot = SL_COINS;
            end
            FC_ANALOG_IN:
            begin
                if (idx == 2'd0)
                    slot = SL_AIN_CH;
                else if (idx == 2'd1)
                    slot = SL_AIN_BITS;
            end
            FC_ROTARY:
            begin
                if (idx == 2'd0)
                    slot = SL_ROTARY;
            end
            FC_GUN:
            begin
                if (idx == 2'd0)
                    slot = SL_GUN_X;
                else if (idx == 2'd1)
                    slot = SL_GUN_Y;
                else if (idx == 2'd2)
                    slot = SL_GUN_CH;
            end
            FC_ANALOG_OUT:
            begin
                if (idx == 2'd0)
                    slot = SL_AOUT_CH;
            end
            default:
            begin
                slot = NO_SLOT;
            end
        endcase
        return slot;
    endfunction

endpackage

FILE: sv/io_capability_report_parser.sv
// Output: a result is registered in the output buffer once the byte that ends
//   the list (or the abnormal status byte) is accepted.
// Throughput: one byte per cycle while the output buffer has room; the
//   phase machine steps per byte; two slots let input flow while a result waits.
// Reset (rst_n low, asynchronous): parser idles, mask and counts clear,
//   output buffer empties, normal status code returns to 1.
module io_capability_report_parser
    import icr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [12:0] feature_mask, [20:13] player_count, [28:21] buttons_per_player,
    // [36:29] coin_slot_count, [44:37] analog_in_channels, [52:45] analog_in_bits,
    // [60:53] rotary_channels, [68:61] gun_x_bits, [76:69] gun_y_bits,
    // [84:77] gun_channels, [92:85] analog_out_channels, [95:93] zero
    output logic [95:0] m_axis_tdata,
    output logic        m_axis_tuser    // [0] parse_status
);

    logic    take;
    logic    res_valid;
    result_t res;
    result_t out_res;

    assign take = s_axis_tvalid && s_axis_tready;

    icr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_take    (take),
        .raw_byte   (s_axis_tdata),
        .first_byte (s_axis_tuser),
        .res_valid  (res_valid),
        .res        (res)
    );

    icr_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_data  (out_res),
        .out_ready (m_axis_tready)
    );

    // Pack the result request onto the stream
    assign m_axis_tdata = {3'b000, out_res.counts, out_res.mask};
    assign m_axis_tuser = out_res.status;

endmodule

FILE: sv/icr_parse.sv
module icr_parse
    import icr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       in_take,
    input  logic [7:0] raw_byte,
    input  logic       first_byte,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]        normal_code_reg;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        code_reg, code_next;
    logic [1:0]        idx_reg, idx_next;
    logic [MASK_W-1:0] seen_reg, seen_next;
    counts_t           counts_reg, counts_next;
    logic [3:0]        slot;

    assign slot = count_slot_for(code_reg, idx_reg);

    // Advance the parse state for one accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        code_next   = code_reg;
        idx_next    = idx_reg;
        seen_next   = seen_reg;
        counts_next = counts_reg;
        res_valid   = 1'b0;
        res.status  = 1'b0;
        res.mask    = seen_reg;
        res.counts  = counts_reg;
        if (in_take)
        begin
            if (first_byte)
            begin
                seen_next   = '0;
                counts_next = '0;
                code_next   = '0;
                idx_next    = '0;
                if (raw_byte != normal_code_reg)
                begin
                    phase_next = PH_IDLE;
                    res_valid  = 1'b1;
                    res.status = 1'b1;
                    res.mask   = '0;
                    res.counts = '0;
                end
                else
                begin
                    phase_next = PH_CODE;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_CODE:
                    begin
                        if (raw_byte == END_CODE)
                        begin
                            phase_next = PH_SUM;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            code_next  = raw_byte;
                            idx_next   = '0;
                            seen_next  = seen_reg | mask_bit_for(raw_byte);
                            phase_next = PH_PARAMS;
                        end
                    end
                    PH_PARAMS:
                    begin
                        if (slot < 4'(NUM_COUNTS))
                            counts_next[slot] = raw_byte;
                        if (idx_reg >= LAST_PARAM)
                        begin
                            idx_next   = '0;
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            idx_next = idx_reg + 2'd1;
                        end
                    end
                    PH_SUM:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Hold the normal status code and parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_code_reg <= NORMAL_RESET;
            phase_reg       <= PH_IDLE;
            code_reg        <= '0;
            idx_reg         <= '0;
            seen_reg        <= '0;
            counts_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
                normal_code_reg <= cfg_wdata;
            phase_reg  <= phase_next;
            code_reg   <= code_next;
            idx_reg    <= idx_next;
            seen_reg   <= seen_next;
            counts_reg <= counts_next;
        end
    end

endmodule

FILE: sv/icr_out.sv
module icr_out
    import icr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Track which of the two result slots hold a request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_valid_reg <= 1'b1;
            else
                main_valid_reg <= 1'b1;
        end
    end

    // Move result payloads between slots
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
                if (push)
                    skid_reg <= push_data;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (main_valid_reg)
                skid_reg <= push_data;
            else
                main_reg <= push_data;
        end
    end

endmodule
